>>> sv/window_minhash_sketch_unit_assert.svh
// Assertion macros shared by the sketch unit modules.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef WINDOW_MINHASH_SKETCH_UNIT_ASSERT_SVH
`define WINDOW_MINHASH_SKETCH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define WMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WMS_ASSERT_IMP(lbl, ante, cons, msg)
`define WMS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> sv/wms_pkg.sv
// Shared constants, command and status types of the window min-hash sketch unit.
// No dependencies.
package wms_pkg;

  localparam int MAX_WINDOW_DEF = 16;
  localparam int MARKER_W       = 32;
  localparam int HASH_W         = 64;
  localparam int WIN_CFG_W      = 5;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 64;

  localparam logic [WIN_CFG_W-1:0] WIN_RESET  = 5'd4;
  localparam logic [HASH_W-1:0]    SEED_RESET = 64'd0;

  // register index, taken from paddr bit 3 (registers at 8-byte spacing)
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_SEED   = 1'b1;

  localparam logic [HASH_W-1:0] MURMUR_M    = 64'hc6a4a7935bd1e995;
  localparam logic [31:0]       MURMUR_M_LO = MURMUR_M[31:0];
  localparam logic [31:0]       MURMUR_M_HI = MURMUR_M[63:32];
  localparam int                MURMUR_R    = 47;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INIT,
    OP_READ,
    OP_READ_TAIL,
    OP_LOAD_K,
    OP_MUL_K,
    OP_MUL_H,
    OP_K_MIX,
    OP_H_SEED,
    OP_H_XK,
    OP_H_PROD,
    OP_H_TAIL,
    OP_H_MIX,
    OP_MIN,
    OP_EMIT
  } wms_op_t;

  typedef struct packed {
    wms_op_t op;
  } wms_cmd_t;

  typedef struct packed {
    logic hash_due;
    logic last;
    logic w_odd;
    logic pair_left;
    logic out_free;
  } wms_status_t;

endpackage

>>> sv/wms_in_if.sv
// Input request channel: one marker identifier and its end-of-read flag.
// Depends on wms_pkg.
interface wms_in_if;
  import wms_pkg::*;

  logic                valid;
  logic                ready;
  logic [MARKER_W-1:0] marker_id;
  logic                end_of_read;

  modport source (output valid, output marker_id, output end_of_read, input ready);
  modport sink   (input valid, input marker_id, input end_of_read, output ready);
endinterface

>>> sv/wms_out_if.sv
// Result request channel: minimum window hash and short-read flag.
// Depends on wms_pkg.
interface wms_out_if;
  import wms_pkg::*;

  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] min_hash;
  logic              short_read;

  modport source (output valid, output min_hash, output short_read, input ready);
  modport sink   (input valid, input min_hash, input short_read, output ready);
endinterface

>>> sv/wms_cfg.sv
// APB-style register file: window length and hash seed.
// Depends on wms_pkg.
module wms_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wms_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wms_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wms_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [wms_pkg::WIN_CFG_W-1:0]    window_markers,
  output logic [wms_pkg::HASH_W-1:0]       hash_seed
);
  import wms_pkg::*;

  logic [WIN_CFG_W-1:0] window_r;
  logic [HASH_W-1:0]    seed_r;
  logic                 wr_en;
  logic                 reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_RESET;
      seed_r   <= SEED_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_WINDOW: window_r <= pwdata[WIN_CFG_W-1:0];
        REG_SEED:   seed_r   <= pwdata[HASH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WINDOW: prdata = CFG_DATA_W'(window_r);
      REG_SEED:   prdata = CFG_DATA_W'(seed_r);
    endcase
  end

  assign window_markers = window_r;
  assign hash_seed      = seed_r;
endmodule

>>> sv/wms_ctrl.sv
// Sequencer of the sketch unit: walks each accepted marker through the hash rounds.
// Depends on wms_pkg and the assertion macro header.
`include "window_minhash_sketch_unit_assert.svh"

module wms_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wms_pkg::wms_status_t st,
  output wms_pkg::wms_cmd_t    cmd
);
  import wms_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_MUL0,
    S_SEED,
    S_RD,
    S_LOAD,
    S_MK1,
    S_KMIX,
    S_MK2,
    S_HXK,
    S_MH,
    S_HPROD,
    S_TRD,
    S_TAIL,
    S_MT,
    S_TPROD,
    S_FMIX,
    S_FMUL,
    S_MIN,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op = OP_INIT;
        priority if (st.hash_due) state_nxt = S_MUL0;
        else if (st.last)         state_nxt = S_EMIT;
        else                      state_nxt = S_IDLE;
      end
      S_MUL0: begin
        cmd.op    = OP_MUL_K;
        state_nxt = S_SEED;
      end
      S_SEED: begin
        cmd.op = OP_H_SEED;
        priority if (st.pair_left) state_nxt = S_RD;
        else if (st.w_odd)         state_nxt = S_TRD;
        else                       state_nxt = S_FMIX;
      end
      S_RD: begin
        cmd.op    = OP_READ;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.op    = OP_LOAD_K;
        state_nxt = S_MK1;
      end
      S_MK1: begin
        cmd.op    = OP_MUL_K;
        state_nxt = S_KMIX;
      end
      S_KMIX: begin
        cmd.op    = OP_K_MIX;
        state_nxt = S_MK2;
      end
      S_MK2: begin
        cmd.op    = OP_MUL_K;
        state_nxt = S_HXK;
      end
      S_HXK: begin
        cmd.op    = OP_H_XK;
        state_nxt = S_MH;
      end
      S_MH: begin
        cmd.op    = OP_MUL_H;
        state_nxt = S_HPROD;
      end
      S_HPROD: begin
        cmd.op = OP_H_PROD;
        priority if (st.pair_left) state_nxt = S_RD;
        else if (st.w_odd)         state_nxt = S_TRD;
        else                       state_nxt = S_FMIX;
      end
      S_TRD: begin
        cmd.op    = OP_READ_TAIL;
        state_nxt = S_TAIL;
      end
      S_TAIL: begin
        cmd.op    = OP_H_TAIL;
        state_nxt = S_MT;
      end
      S_MT: begin
        cmd.op    = OP_MUL_H;
        state_nxt = S_TPROD;
      end
      S_TPROD: begin
        cmd.op    = OP_H_PROD;
        state_nxt = S_FMIX;
      end
      S_FMIX: begin
        cmd.op    = OP_H_MIX;
        state_nxt = S_FMUL;
      end
      S_FMUL: begin
        cmd.op    = OP_MUL_H;
        state_nxt = S_MIN;
      end
      S_MIN: begin
        cmd.op    = OP_MIN;
        state_nxt = st.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  `WMS_ASSERT_IMP(a_rd_has_pair, state_r == S_RD, st.pair_left, "pair read with no pair left")
  `WMS_ASSERT_IMP(a_emit_slot_free, cmd.op == OP_EMIT, st.out_free, "emit over a pending result")
  `WMS_ASSERT_NXT(a_accept_to_init, in_valid && in_ready, state_r == S_INIT, "accept not followed by init")
endmodule

>>> sv/wms_dp.sv
// Datapath: circular marker store, shared 64-bit multiply by the hash constant,
// hash and running-minimum registers, output register. Depends on wms_pkg and macros.
`include "window_minhash_sketch_unit_assert.svh"

module wms_dp #(
  parameter int MAX_WINDOW = wms_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wms_pkg::wms_cmd_t               cmd,
  output wms_pkg::wms_status_t            st,
  input  logic [wms_pkg::WIN_CFG_W-1:0]   cfg_window,
  input  logic [wms_pkg::HASH_W-1:0]      cfg_seed,
  input  logic [wms_pkg::MARKER_W-1:0]    marker_id,
  input  logic                            end_of_read,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [wms_pkg::HASH_W-1:0]      out_min_hash,
  output logic                            out_short_read
);
  import wms_pkg::*;

  localparam int PW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int AW    = $clog2(2 * MAX_WINDOW) + 1;
  localparam int PAIRW = $clog2(MAX_WINDOW / 2 + 2);
  localparam logic [CW-1:0] SEEN_MAX = CW'(MAX_WINDOW);
  localparam logic [PW-1:0] PTR_LAST = PW'(MAX_WINDOW - 1);

  logic [MARKER_W-1:0] mem [MAX_WINDOW];

  logic [PW-1:0]       wr_r;
  logic [PW-1:0]       rd_ptr_r;
  logic [CW-1:0]       seen_r;
  logic [CW-1:0]       w_r;
  logic                last_r;
  logic [PAIRW-1:0]    pair_cnt_r;
  logic [HASH_W-1:0]   min_r;
  logic                out_valid_r;
  logic [HASH_W-1:0]   out_min_r;
  logic                out_short_r;

  logic [HASH_W-1:0]   k_r;
  logic [HASH_W-1:0]   h_r;
  logic [MARKER_W-1:0] rd_a_r;
  logic [MARKER_W-1:0] rd_b_r;
  logic [63:0]         pp_lo_r;
  logic [31:0]         pp_x1_r;
  logic [31:0]         pp_x2_r;

  logic [CW-1:0]       w_eff;
  logic [CW-1:0]       seen_nxt;
  logic [AW-1:0]       oldest_sum;
  logic [PW-1:0]       oldest;
  logic [PW-1:0]       newest;
  logic [PW-1:0]       rd_a_addr;
  logic [PW-1:0]       rd_b_addr;
  logic [HASH_W-1:0]   mul_src;
  logic [63:0]         pp_lo_nxt;
  logic [31:0]         pp_x1_nxt;
  logic [31:0]         pp_x2_nxt;
  logic [HASH_W-1:0]   prod;
  logic [HASH_W-1:0]   fin_hash;
  logic                is_short;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  // zero acts as one, oversize clamps to the store depth
  always_comb begin
    priority if (cfg_window == '0)                      w_eff = CW'(1);
    else if (32'(cfg_window) > 32'(MAX_WINDOW))         w_eff = SEEN_MAX;
    else                                                w_eff = CW'(cfg_window);
  end

  assign seen_nxt = (seen_r == SEEN_MAX) ? seen_r : seen_r + CW'(1);

  // oldest marker of the window sits w entries behind the write pointer
  always_comb begin
    oldest_sum = AW'(wr_r) + AW'(MAX_WINDOW) - AW'(w_r);
    if (oldest_sum >= AW'(MAX_WINDOW)) begin
      oldest_sum = oldest_sum - AW'(MAX_WINDOW);
    end
    oldest = PW'(oldest_sum);
  end

  assign newest    = (wr_r == '0) ? PTR_LAST : wr_r - PW'(1);
  assign rd_a_addr = (cmd.op == OP_READ_TAIL) ? newest : rd_ptr_r;
  assign rd_b_addr = ptr_inc(rd_ptr_r);

  // 64x64 low product split into one full and two half 32x32 partials
  assign mul_src   = (cmd.op == OP_MUL_H) ? h_r : k_r;
  assign pp_lo_nxt = 64'(mul_src[31:0]) * 64'(MURMUR_M_LO);
  assign pp_x1_nxt = mul_src[63:32] * MURMUR_M_LO;
  assign pp_x2_nxt = mul_src[31:0] * MURMUR_M_HI;
  assign prod      = pp_lo_r + {pp_x1_r + pp_x2_r, 32'b0};
  assign fin_hash  = prod ^ (prod >> MURMUR_R);

  assign is_short = seen_r < w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r        <= '0;
      rd_ptr_r    <= '0;
      seen_r      <= '0;
      w_r         <= CW'(1);
      last_r      <= 1'b0;
      pair_cnt_r  <= '0;
      min_r       <= '1;
      out_valid_r <= 1'b0;
    end else begin
      // a new result only loads once the old one is taken
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_ACCEPT: begin
          wr_r   <= ptr_inc(wr_r);
          seen_r <= seen_nxt;
          w_r    <= w_eff;
          last_r <= end_of_read;
        end
        OP_INIT: begin
          rd_ptr_r   <= oldest;
          pair_cnt_r <= PAIRW'(w_r >> 1);
        end
        OP_READ: begin
          rd_ptr_r   <= ptr_inc(rd_b_addr);
          pair_cnt_r <= pair_cnt_r - PAIRW'(1);
        end
        OP_MIN: begin
          if (fin_hash < min_r) begin
            min_r <= fin_hash;
          end
        end
        OP_EMIT: begin
          seen_r <= '0;
          min_r  <= '1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      mem[wr_r] <= marker_id;
    end
    if (cmd.op == OP_READ || cmd.op == OP_READ_TAIL) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
    if (cmd.op == OP_MUL_K || cmd.op == OP_MUL_H) begin
      pp_lo_r <= pp_lo_nxt;
      pp_x1_r <= pp_x1_nxt;
      pp_x2_r <= pp_x2_nxt;
    end
    case (cmd.op)
      OP_INIT:    k_r <= HASH_W'(w_r) << 2;
      OP_LOAD_K:  k_r <= {rd_b_r, rd_a_r};
      OP_K_MIX:   k_r <= fin_hash;
      OP_H_SEED:  h_r <= cfg_seed ^ prod;
      OP_H_XK:    h_r <= h_r ^ prod;
      OP_H_PROD:  h_r <= prod;
      OP_H_TAIL:  h_r <= h_r ^ HASH_W'(rd_a_r);
      OP_H_MIX:   h_r <= h_r ^ (h_r >> MURMUR_R);
      OP_EMIT: begin
        out_min_r   <= is_short ? '1 : min_r;
        out_short_r <= is_short;
      end
      default: ;
    endcase
  end

  assign st.hash_due  = (seen_r >= w_r);
  assign st.last      = last_r;
  assign st.w_odd     = w_r[0];
  assign st.pair_left = (pair_cnt_r != '0);
  assign st.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_min_hash   = out_min_r;
  assign out_short_read = out_short_r;

  `WMS_ASSERT_IMP(a_seen_bound, 1'b1, seen_r <= SEEN_MAX, "marker count above store depth")
  `WMS_ASSERT_IMP(a_short_all_ones, out_valid_r && out_short_r, out_min_r == '1, "short read without all-ones hash")
  `WMS_ASSERT_NXT(a_emit_valid, cmd.op == OP_EMIT, out_valid_r && seen_r == '0, "emit did not load result")
  `WMS_ASSERT_NXT(a_accept_counts, cmd.op == OP_ACCEPT, seen_r != '0, "accepted marker not counted")
endmodule

>>> sv/window_minhash_sketch_unit.sv
// Usage: a read's marker identifiers arrive on in_ch, one per request, the last one
// flagged by end_of_read. Each full window of window_markers markers is hashed with
// MurmurHash64A under hash_seed; at the last marker one result leaves on out_ch:
// the smallest window hash, or all ones with short_read set if the read was shorter
// than the window. Registers: window_markers at byte 0, hash_seed at byte 8.
// A single shared 64-bit constant multiplier serves all hash rounds and takes three
// products per 8-byte block. Markers are taken one at a time.
// A result sits in an output register; the next read's markers are accepted while it
// waits, and only a following end-of-read marker holds until out_ch takes it.
// Reset (synchronous, rst_n low) restores window_markers 4, seed 0, clears the marker
// count, presets the running minimum to all ones, drops any pending result; store not cleared.
module window_minhash_sketch_unit #(
  parameter int MAX_WINDOW = wms_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  wms_in_if.sink                          in_ch,
  wms_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [wms_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [wms_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [wms_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import wms_pkg::*;

  wms_cmd_t             cmd;
  wms_status_t          st;
  logic [WIN_CFG_W-1:0] window_markers;
  logic [HASH_W-1:0]    hash_seed;
  logic                 in_ready;

  wms_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (cfg_psel),
    .penable        (cfg_penable),
    .pwrite         (cfg_pwrite),
    .paddr          (cfg_paddr),
    .pwdata         (cfg_pwdata),
    .prdata         (cfg_prdata),
    .pready         (cfg_pready),
    .window_markers (window_markers),
    .hash_seed      (hash_seed)
  );

  wms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  wms_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .cfg_window     (window_markers),
    .cfg_seed       (hash_seed),
    .marker_id      (in_ch.marker_id),
    .end_of_read    (in_ch.end_of_read),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_min_hash   (out_ch.min_hash),
    .out_short_read (out_ch.short_read)
  );

  assign in_ch.ready = in_ready;
endmodule
